/* design/ddodo_pkg.sv */
// ----------------------------------------------------------------------------
// ddodo_pkg: shared types and constants of the odometry block
// Field widths, fixed-point formats, multiplier operand codes, register
// indexes, the arctangent table of the rotation unit and the command word
// that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package ddodo_pkg;

   localparam int SPEED_W    = 11;
   localparam int SUM_W      = 12;
   localparam int CFG_W      = 24;
   localparam int POSE_W     = 32;
   localparam int TRIG_W     = 26;
   localparam int MULA_W     = 25;
   localparam int MULB_W     = 26;
   localparam int PROD_W     = MULA_W + MULB_W;
   localparam int M_W        = 36;
   localparam int M_SPLIT    = 18;
   localparam int ACC_W      = 62;
   localparam int RESULT_SHIFT = 41;
   localparam int ATAN_LEN   = 24;
   localparam int ATAN_IDX_W = 5;

   localparam logic [SPEED_W-1:0] SPEED_MIN = 11'h400;
   localparam logic [SPEED_W-1:0] SPEED_SAT = 11'h401;

   localparam logic signed [POSE_W-1:0] CORDIC_GAIN = 32'sd652032874;
   localparam logic signed [ACC_W-1:0]  ROUND_BIAS  = 62'sh100_0000_0000;
   localparam logic signed [POSE_W-1:0] Q24_MAX     = 32'sh0100_0000;

   localparam logic [CFG_W-1:0] DIST_RESET = 24'd353877;
   localparam logic [CFG_W-1:0] TURN_RESET = 24'd1083103;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN = 1'b1;

   localparam int MUL_SEL_W = 3;
   localparam logic [MUL_SEL_W-1:0] MUL_DIST   = 3'd0;
   localparam logic [MUL_SEL_W-1:0] MUL_TURN   = 3'd1;
   localparam logic [MUL_SEL_W-1:0] MUL_SIN_LO = 3'd2;
   localparam logic [MUL_SEL_W-1:0] MUL_SIN_HI = 3'd3;
   localparam logic [MUL_SEL_W-1:0] MUL_COS_LO = 3'd4;
   localparam logic [MUL_SEL_W-1:0] MUL_COS_HI = 3'd5;

   typedef struct packed {
      logic                 load;
      logic                 cordic_step;
      logic                 trig_load;
      logic [MUL_SEL_W-1:0] mul_sel;
      logic                 m_load;
      logic                 dth_load;
      logic                 acc_init;
      logic                 acc_add;
      logic                 dx_load;
      logic                 dy_load;
      logic                 commit;
   } dp_cmd_type;

   function automatic logic signed [POSE_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [POSE_W-1:0] val;
      case (idx)
         5'd0:    val = 32'sd536870912;
         5'd1:    val = 32'sd316933406;
         5'd2:    val = 32'sd167458907;
         5'd3:    val = 32'sd85004756;
         5'd4:    val = 32'sd42667331;
         5'd5:    val = 32'sd21354465;
         5'd6:    val = 32'sd10679838;
         5'd7:    val = 32'sd5340245;
         5'd8:    val = 32'sd2670163;
         5'd9:    val = 32'sd1335087;
         5'd10:   val = 32'sd667544;
         5'd11:   val = 32'sd333772;
         5'd12:   val = 32'sd166886;
         5'd13:   val = 32'sd83443;
         5'd14:   val = 32'sd41722;
         5'd15:   val = 32'sd20861;
         5'd16:   val = 32'sd10430;
         5'd17:   val = 32'sd5215;
         5'd18:   val = 32'sd2608;
         5'd19:   val = 32'sd1304;
         5'd20:   val = 32'sd652;
         5'd21:   val = 32'sd326;
         5'd22:   val = 32'sd163;
         5'd23:   val = 32'sd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

/* design/ddodo_ctrl.sv */
// ----------------------------------------------------------------------------
// ddodo_ctrl: sequencing controller
// Accepts one word, runs the rotation iterations, steps the shared multiplier
// through its six products and commits the new pose when the result slot
// is free.
// ----------------------------------------------------------------------------
module ddodo_ctrl
   import ddodo_pkg::*;
#(
   parameter int CORDIC_STEPS = 16,
   localparam int ITER_W = $clog2(CORDIC_STEPS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dp_cmd_type        dp_cmd,
   output logic [ITER_W-1:0] cordic_iter
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CORDIC = 4'd1;
   localparam logic [3:0] S_TRIG   = 4'd2;
   localparam logic [3:0] S_M1     = 4'd3;
   localparam logic [3:0] S_M2     = 4'd4;
   localparam logic [3:0] S_M3     = 4'd5;
   localparam logic [3:0] S_M4     = 4'd6;
   localparam logic [3:0] S_M5     = 4'd7;
   localparam logic [3:0] S_M6     = 4'd8;
   localparam logic [3:0] S_M7     = 4'd9;
   localparam logic [3:0] S_DONE   = 4'd10;

   localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STEPS - 1);

   logic [3:0]        state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              rsp_valid_ff, rsp_valid_in;

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign cordic_iter = iter_ff;

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      dp_cmd   = '0;
      dp_cmd.mul_sel = MUL_DIST;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.load = 1'b1;
               iter_in     = '0;
               state_in    = S_CORDIC;
            end
         end
         S_CORDIC: begin
            dp_cmd.cordic_step = 1'b1;
            if (iter_ff == LAST_ITER) begin
               iter_in  = '0;
               state_in = S_TRIG;
            end else begin
               iter_in = iter_ff + 1'b1;
            end
         end
         S_TRIG: begin
            dp_cmd.trig_load = 1'b1;
            dp_cmd.mul_sel   = MUL_DIST;
            state_in         = S_M1;
         end
         S_M1: begin
            dp_cmd.m_load  = 1'b1;
            dp_cmd.mul_sel = MUL_TURN;
            state_in       = S_M2;
         end
         S_M2: begin
            dp_cmd.dth_load = 1'b1;
            dp_cmd.mul_sel  = MUL_SIN_LO;
            state_in        = S_M3;
         end
         S_M3: begin
            dp_cmd.acc_init = 1'b1;
            dp_cmd.mul_sel  = MUL_SIN_HI;
            state_in        = S_M4;
         end
         S_M4: begin
            dp_cmd.acc_add = 1'b1;
            dp_cmd.mul_sel = MUL_COS_LO;
            state_in       = S_M5;
         end
         S_M5: begin
            dp_cmd.dx_load  = 1'b1;
            dp_cmd.acc_init = 1'b1;
            dp_cmd.mul_sel  = MUL_COS_HI;
            state_in        = S_M6;
         end
         S_M6: begin
            dp_cmd.acc_add = 1'b1;
            state_in       = S_M7;
         end
         S_M7: begin
            dp_cmd.dy_load = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               dp_cmd.commit = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (dp_cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* design/ddodo_dp.sv */
// ----------------------------------------------------------------------------
// ddodo_dp: odometry datapath
// Holds the pose and the two scale registers, the iterative rotation unit for
// sine and cosine, one shared signed multiplier and the rounding accumulator.
// ----------------------------------------------------------------------------
module ddodo_dp
   import ddodo_pkg::*;
#(
   parameter int ANGLE_BITS   = 32,
   parameter int CORDIC_STEPS = 16,
   localparam int ITER_W = $clog2(CORDIC_STEPS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 dp_cmd,
   input  logic [ITER_W-1:0]          cordic_iter,
   input  logic signed [SPEED_W-1:0]  req_left_speed,
   input  logic signed [SPEED_W-1:0]  req_right_speed,
   input  logic                       csr_write_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CFG_W-1:0]           csr_wdata,
   output logic signed [POSE_W-1:0]   rsp_pose_x,
   output logic signed [POSE_W-1:0]   rsp_pose_y,
   output logic [POSE_W-1:0]          rsp_pose_heading
);

   localparam logic [POSE_W-1:0] ANGLE_MASK = ~(32'hFFFF_FFFF >> ANGLE_BITS);

   logic [CFG_W-1:0]          dist_ff, dist_in, turn_ff, turn_in;
   logic signed [POSE_W-1:0]  pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [POSE_W-1:0]         heading_ff, heading_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in, diff_ff, diff_in;
   logic signed [POSE_W-1:0]  x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [1:0]                quad_ff, quad_in;
   logic signed [TRIG_W-1:0]  sin_ff, sin_in, cos_ff, cos_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [M_W-1:0]     m_ff, m_in;
   logic [POSE_W-1:0]         dth_ff, dth_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [POSE_W-1:0]  dx_ff, dx_in, dy_ff, dy_in;

   logic signed [SPEED_W-1:0] left_sat, right_sat;
   logic [POSE_W-1:0]         angle_masked, angle_biased;
   logic signed [POSE_W-1:0]  x_shift, y_shift, atan_val;
   logic signed [POSE_W-1:0]  sin_raw, cos_raw;
   logic signed [MULA_W-1:0]  mul_a;
   logic signed [MULB_W-1:0]  mul_b;

   function automatic logic signed [SPEED_W-1:0] saturate(input logic signed [SPEED_W-1:0] s);
      return (s == SPEED_MIN) ? SPEED_SAT : s;
   endfunction

   function automatic logic signed [TRIG_W-1:0] to_q24(input logic signed [POSE_W-1:0] v);
      logic signed [POSE_W-1:0] r;
      r = (v + 32'sd32) >>> 6;
      if (r > Q24_MAX) begin
         r = Q24_MAX;
      end else if (r < -Q24_MAX) begin
         r = -Q24_MAX;
      end
      return TRIG_W'(r);
   endfunction

   assign rsp_pose_x       = pos_x_ff;
   assign rsp_pose_y       = pos_y_ff;
   assign rsp_pose_heading = heading_ff;

   assign left_sat     = saturate(req_left_speed);
   assign right_sat    = saturate(req_right_speed);
   assign angle_masked = heading_ff & ANGLE_MASK;
   assign angle_biased = angle_masked + 32'h2000_0000;
   assign x_shift      = x_ff >>> cordic_iter;
   assign y_shift      = y_ff >>> cordic_iter;
   assign atan_val     = atan_entry(ATAN_IDX_W'(cordic_iter));

   // Rotate the result for the reduced angle back by the quarter turns taken off.
   always_comb begin
      case (quad_ff)
         2'd0: begin
            sin_raw = y_ff;
            cos_raw = x_ff;
         end
         2'd1: begin
            sin_raw = x_ff;
            cos_raw = -y_ff;
         end
         2'd2: begin
            sin_raw = -y_ff;
            cos_raw = -x_ff;
         end
         default: begin
            sin_raw = -x_ff;
            cos_raw = y_ff;
         end
      endcase
   end

   always_comb begin
      case (dp_cmd.mul_sel)
         MUL_DIST: begin
            mul_a = $signed({1'b0, dist_ff});
            mul_b = MULB_W'(sum_ff);
         end
         MUL_TURN: begin
            mul_a = $signed({1'b0, turn_ff});
            mul_b = MULB_W'(diff_ff);
         end
         MUL_SIN_LO: begin
            mul_a = $signed({{(MULA_W-M_SPLIT){1'b0}}, m_ff[M_SPLIT-1:0]});
            mul_b = sin_ff;
         end
         MUL_SIN_HI: begin
            mul_a = MULA_W'($signed(m_ff[M_W-1:M_SPLIT]));
            mul_b = sin_ff;
         end
         MUL_COS_LO: begin
            mul_a = $signed({{(MULA_W-M_SPLIT){1'b0}}, m_ff[M_SPLIT-1:0]});
            mul_b = cos_ff;
         end
         MUL_COS_HI: begin
            mul_a = MULA_W'($signed(m_ff[M_W-1:M_SPLIT]));
            mul_b = cos_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      dist_in = dist_ff;
      turn_in = turn_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_DIST: dist_in = csr_wdata;
            CSR_TURN: turn_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      sum_in  = sum_ff;
      diff_in = diff_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      quad_in = quad_ff;
      if (dp_cmd.load) begin
         sum_in  = SUM_W'(left_sat) + SUM_W'(right_sat);
         diff_in = SUM_W'(right_sat) - SUM_W'(left_sat);
         quad_in = angle_biased[POSE_W-1:POSE_W-2];
         z_in    = $signed(angle_masked - {angle_biased[POSE_W-1:POSE_W-2], 30'b0});
         x_in    = CORDIC_GAIN;
         y_in    = '0;
      end else if (dp_cmd.cordic_step) begin
         if (!z_ff[POSE_W-1]) begin
            x_in = x_ff - y_shift;
            y_in = y_ff + x_shift;
            z_in = z_ff - atan_val;
         end else begin
            x_in = x_ff + y_shift;
            y_in = y_ff - x_shift;
            z_in = z_ff + atan_val;
         end
      end
   end

   always_comb begin
      sin_in = dp_cmd.trig_load ? to_q24(sin_raw) : sin_ff;
      cos_in = dp_cmd.trig_load ? to_q24(cos_raw) : cos_ff;
      m_in   = dp_cmd.m_load ? M_W'(prod_ff) : m_ff;
      dth_in = dp_cmd.dth_load ? POSE_W'(prod_ff) : dth_ff;
      dx_in  = dp_cmd.dx_load ? POSE_W'(acc_ff >>> RESULT_SHIFT) : dx_ff;
      dy_in  = dp_cmd.dy_load ? POSE_W'(acc_ff >>> RESULT_SHIFT) : dy_ff;
      if (dp_cmd.acc_init) begin
         acc_in = ACC_W'(prod_ff) + ROUND_BIAS;
      end else if (dp_cmd.acc_add) begin
         acc_in = acc_ff + (ACC_W'(prod_ff) <<< M_SPLIT);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_comb begin
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      heading_in = heading_ff;
      if (dp_cmd.commit) begin
         pos_x_in   = pos_x_ff - dx_ff;
         pos_y_in   = pos_y_ff - dy_ff;
         heading_in = heading_ff + dth_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff    <= DIST_RESET;
         turn_ff    <= TURN_RESET;
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         heading_ff <= '0;
      end else begin
         dist_ff    <= dist_in;
         turn_ff    <= turn_in;
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
         heading_ff <= heading_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      diff_ff <= diff_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      quad_ff <= quad_in;
      sin_ff  <= sin_in;
      cos_ff  <= cos_in;
      prod_ff <= prod_in;
      m_ff    <= m_in;
      dth_ff  <= dth_in;
      acc_ff  <= acc_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
   end

endmodule

/* design/differential_drive_odometry.sv */
// ----------------------------------------------------------------------------
// differential_drive_odometry: dead-reckoning pose integrator
// A new word is accepted only when idle, so one word is worked through at a
// time; the pace is set by the iterative rotation unit and six passes through
// one shared multiplier, and a result not yet taken holds back the commit.
// Reset clears the pose, restores both scale registers and drops any result.
// ----------------------------------------------------------------------------
module differential_drive_odometry
   import ddodo_pkg::*;
#(
   parameter int ANGLE_BITS   = 32,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [SPEED_W-1:0] req_left_speed,
   input  logic signed [SPEED_W-1:0] req_right_speed,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [POSE_W-1:0]  rsp_pose_x,
   output logic signed [POSE_W-1:0]  rsp_pose_y,
   output logic [POSE_W-1:0]         rsp_pose_heading,
   input  logic                      csr_write_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CFG_W-1:0]          csr_wdata
);

   localparam int ITER_W = $clog2(CORDIC_STEPS);

   dp_cmd_type        dp_cmd;
   logic [ITER_W-1:0] cordic_iter;

   ddodo_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .dp_cmd      (dp_cmd),
      .cordic_iter (cordic_iter)
   );

   ddodo_dp #(
      .ANGLE_BITS  (ANGLE_BITS),
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .dp_cmd          (dp_cmd),
      .cordic_iter     (cordic_iter),
      .req_left_speed  (req_left_speed),
      .req_right_speed (req_right_speed),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_pose_x      (rsp_pose_x),
      .rsp_pose_y      (rsp_pose_y),
      .rsp_pose_heading(rsp_pose_heading)
   );

endmodule

/* design/ddodo_checker.sv */
// ----------------------------------------------------------------------------
// ddodo_checker: port-level checks of the odometry block
// Watches the request and response channels over time and is bound to the
// top level.
// ----------------------------------------------------------------------------
module ddodo_checker
   import ddodo_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [POSE_W-1:0]  rsp_pose_x,
   input logic signed [POSE_W-1:0]  rsp_pose_y,
   input logic [POSE_W-1:0]         rsp_pose_heading
);

   // No result is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // A waiting result keeps its pose until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pose_x)
         && $stable(rsp_pose_y) && $stable(rsp_pose_heading))
      else $error("waiting result changed");

   // An accepted word makes the block busy, so req_ready goes low after it.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("request taken while busy");

   // A new result appears exactly as the block becomes free again.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result offered while still busy");

endmodule

bind differential_drive_odometry ddodo_checker u_checker (.*);
